@@ rtl/dsel_pkg.sv @@
// Package for the depth-sorted entry list: transaction payload types,
// operation and status codes, and the cell control types.
// No dependencies.
`default_nettype none

package dsel_pkg;

    localparam int HANDLE_W     = 8;
    localparam int KEY_W        = 10;
    localparam int OUT_CNT_W    = 5;
    localparam int DEF_CAPACITY = 16;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_CLEAR  = 2'd2,
        K_ENUM   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_PRESENT = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] entry_handle;
        logic [KEY_W-1:0]    sort_key;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  out_handle;
        logic                 is_viewer;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_entry;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS,
        OP_REM,
        OP_ROT,
        OP_CLR
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/dsel_cell.sv @@
// One slot of the sorted entry chain: holds one entry and shifts it to or
// from its neighbors on insert, remove and rotate. Uses dsel_pkg.
`default_nettype none

module dsel_cell
    import dsel_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_left,
    input  wire t_entry    i_right,
    input  wire t_entry    i_head,
    input  wire logic      i_left_gt,
    input  wire logic      i_left_hit,
    output t_entry         o_entry,
    output logic           o_gt,
    output logic           o_hit,
    output logic           o_match
);

    t_entry r_entry;
    t_entry n_entry;

    // empty slot sorts as infinite key
    assign o_gt    = !r_entry.valid || (r_entry.key > i_ctl.key);
    assign o_match = r_entry.valid && (r_entry.handle == i_ctl.handle);
    assign o_hit   = i_left_hit || o_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INS: begin
                if (o_gt) begin
                    if (i_left_gt) begin
                        n_entry = i_left;
                    end else begin
                        n_entry.valid  = 1'b1;
                        n_entry.handle = i_ctl.handle;
                        n_entry.key    = i_ctl.key;
                    end
                end
            end
            OP_REM: begin
                if (o_hit) begin
                    n_entry = i_right;
                end
            end
            OP_ROT: begin
                if (r_entry.valid) begin
                    n_entry = i_right.valid ? i_right : i_head;
                end
            end
            OP_CLR: begin
                n_entry.valid = 1'b0;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/depth_sorted_entry_list_top.sv @@
// Depth-sorted entry list: a chain of CAPACITY slots kept in ascending key
// order. Insert, remove and clear each give one registered result in the
// cycle after they are accepted; enumerate gives held+1 results, one per
// cycle while the output is not stalled, by rotating the chain past its head
// slot. Input is stalled while an enumerate runs or while an unaccepted
// result blocks the output register. Uses dsel_pkg, dsel_cell.
`default_nettype none

module depth_sorted_entry_list_top
    import dsel_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_out_item     o_out_data,
    input  wire logic     i_out_stall
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_ENUM
    } t_state;

    t_state    r_state,     n_state;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out,       n_out;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_left,  n_left;
    logic             r_vdone, n_vdone;
    logic [KEY_W-1:0] r_vkey,  n_vkey;

    t_cell_ctl w_ctl;
    t_entry    w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_valid;
    logic      w_out_free;
    logic      w_accept;
    logic      w_full;
    logic      w_dup;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_lgt;
            logic   w_lhit;
            if (gi == 0) begin : g_first
                assign w_left = '0;
                assign w_lgt  = 1'b0;
                assign w_lhit = 1'b0;
            end else begin : g_mid
                assign w_left = w_entry[gi-1];
                assign w_lgt  = w_gt[gi-1];
                assign w_lhit = w_hit[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_entry[gi+1];
            end
            dsel_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_head     (w_entry[0]),
                .i_left_gt  (w_lgt),
                .i_left_hit (w_lhit),
                .o_entry    (w_entry[gi]),
                .o_gt       (w_gt[gi]),
                .o_hit      (w_hit[gi]),
                .o_match    (w_match[gi])
            );
            assign w_valid[gi] = w_entry[gi].valid;
        end
    endgenerate

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_dup       = |w_match;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_count     = r_count;
        n_left      = r_left;
        n_vdone     = r_vdone;
        n_vkey      = r_vkey;
        w_ctl.op     = OP_HOLD;
        w_ctl.handle = i_in_data.entry_handle;
        w_ctl.key    = i_in_data.sort_key;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out.status     = ST_DONE;
                    n_out.out_handle = '0;
                    n_out.is_viewer  = 1'b0;
                    n_out.last       = 1'b1;
                    n_out_valid      = 1'b1;
                    case (i_in_data.kind)
                        K_INSERT: begin
                            if (w_full) begin
                                n_out.status = ST_FULL;
                            end else if (w_dup) begin
                                n_out.status = ST_PRESENT;
                            end else begin
                                w_ctl.op = OP_INS;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        K_REMOVE: begin
                            if (w_dup) begin
                                w_ctl.op = OP_REM;
                                n_count  = r_count - CW'(1);
                            end else begin
                                n_out.status = ST_ABSENT;
                            end
                        end
                        K_CLEAR: begin
                            w_ctl.op = OP_CLR;
                            n_count  = '0;
                        end
                        K_ENUM: begin
                            n_out_valid = r_out_valid && i_out_stall;
                            n_out       = r_out;
                            n_left      = r_count;
                            n_vdone     = 1'b0;
                            n_vkey      = i_in_data.sort_key;
                            n_state     = S_ENUM;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                    n_out.entry_count = OUT_CNT_W'(n_count);
                end
            end
            S_ENUM: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = ST_DONE;
                    n_out.entry_count = OUT_CNT_W'(r_count);
                    n_out.out_handle  = '0;
                    n_out.is_viewer   = 1'b1;
                    n_out.last        = 1'b0;
                    if (r_left == '0) begin
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end else if (!r_vdone && (w_entry[0].key >= r_vkey)) begin
                        n_vdone = 1'b1;
                    end else begin
                        w_ctl.op         = OP_ROT;
                        n_out.out_handle = w_entry[0].handle;
                        n_out.is_viewer  = 1'b0;
                        n_out.last       = (r_left == CW'(1)) && r_vdone;
                        n_left           = r_left - CW'(1);
                        if (n_out.last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_left      <= '0;
            r_vdone     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_left      <= n_left;
            r_vdone     <= n_vdone;
        end
        r_out  <= n_out;
        r_vkey <= n_vkey;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count above capacity");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (($countones(w_valid) == int'(r_count))
         && ((w_valid & (w_valid + CAPACITY'(1))) == '0)))
        else $error("valid slots not packed or not matching held count");

    a_enum_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENUM) |=> $stable(r_count))
        else $error("held count changed during enumerate");

    a_enum_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ENUM) && (n_state == S_IDLE)) |-> (n_left == '0))
        else $error("enumerate ended before full rotation");

endmodule

`default_nettype wire
